// ===== rtl/vrpf_pkg.sv =====
// Shared types and fixed field widths for the vector range predicate filter.
// No dependencies; every other file of the block refers to it by scoped names.
package vrpf_pkg;

  // Fixed widths of the word fields on the input channel
  localparam int unsigned SlotW  = 4;
  localparam int unsigned GroupW = 4;
  localparam int unsigned DimW   = 10;
  localparam int unsigned ValueW = 32;

  // Operation carried by an input word
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_ELEM  = 2'd2
  } func_e;

  // One input word as held in the input register
  typedef struct packed {
    func_e                    func;
    logic [SlotW-1:0]         slot;
    logic [GroupW-1:0]        group;
    logic [DimW-1:0]          rule_dim;
    logic signed [ValueW-1:0] range_low;
    logic signed [ValueW-1:0] range_high;
    logic [DimW-1:0]          elem_index;
    logic signed [ValueW-1:0] elem_value;
    logic                     last;
  } item_t;

  // Table update strobes, already qualified by the stage advancing
  typedef struct packed {
    logic load;
    logic clear;
  } bank_ctrl_t;

endpackage

// ===== rtl/vector_range_predicate_filter.sv =====
// Top level of the vector range predicate filter: input register, rule bank,
// group hit tracking and the result register. Depends on vrpf_pkg,
// vrpf_in_stage and vrpf_rule_bank.
//
// Usage: one input channel (in_valid_i / in_ready_o) carries words that load a
// rule into a slot, clear the whole table, or stream one vector element.
// Each rule names a group, a dimension and an inclusive signed Q23.8 range.
// An element hits every group whose rule matches its index and holds its
// value. The element flagged last produces one word on the output channel
// (out_valid_o / out_ready_i): vector_ok_o is high when every group that owns
// a rule was hit during the vector; an empty table passes. Other words give
// no output.
// Throughput: one word per cycle, except while a last element waits for a
// blocked result register; all rules compare in parallel in the cycle after
// capture. Each result passes the input register and then the result register.
// Reset clears the rule valid bits, the group hit mask and both valid flags.
// When the receiver stalls, the result register holds its word and the
// input register keeps taking words that give no result; a last element
// waits in the input register until the result register frees.
module vector_range_predicate_filter #(
  parameter int unsigned RULES      = 16,
  parameter int unsigned GROUPS     = 16,
  parameter int unsigned DIM_BITS   = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         slot_i,
  input  logic [3:0]         group_i,
  input  logic [9:0]         rule_dim_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic [9:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               vector_ok_o
);

  vrpf_pkg::item_t      in_item;
  vrpf_pkg::item_t      s1_item;
  vrpf_pkg::bank_ctrl_t bank_ctrl;
  logic                 s1_valid;
  logic                 advance;
  logic                 gives_result;
  logic [GROUPS-1:0]    hit_groups;
  logic [GROUPS-1:0]    need_groups;
  logic [GROUPS-1:0]    mask_q, mask_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ok_q;
  logic                 ok_now;

  // Gather the input word
  always_comb begin
    in_item            = '0;
    in_item.func       = vrpf_pkg::func_e'(func_i);
    in_item.slot       = slot_i;
    in_item.group      = group_i;
    in_item.rule_dim   = rule_dim_i;
    in_item.range_low  = range_low_i;
    in_item.range_high = range_high_i;
    in_item.elem_index = elem_index_i;
    in_item.elem_value = elem_value_i;
    in_item.last       = last_i;
  end

  vrpf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // Advance unless a result is due and the result register is blocked
  assign gives_result = (s1_item.func == vrpf_pkg::FUNC_ELEM) && s1_item.last;
  assign advance      = s1_valid && (!gives_result || !out_valid_q || out_ready_i);

  assign bank_ctrl.load  = advance && (s1_item.func == vrpf_pkg::FUNC_LOAD);
  assign bank_ctrl.clear = advance && (s1_item.func == vrpf_pkg::FUNC_CLEAR);

  vrpf_rule_bank #(
    .RULES      (RULES),
    .GROUPS     (GROUPS),
    .DIM_BITS   (DIM_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_rule_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (bank_ctrl),
    .item_i        (s1_item),
    .hit_groups_o  (hit_groups),
    .need_groups_o (need_groups)
  );

  // Verdict includes the last element's own hits
  assign ok_now = ((need_groups & ~(mask_q | hit_groups)) == '0);

  // Update the group hit mask
  always_comb begin
    mask_d = mask_q;
    if (advance) begin
      case (s1_item.func)
        vrpf_pkg::FUNC_CLEAR: begin
          mask_d = '0;
        end
        vrpf_pkg::FUNC_ELEM: begin
          mask_d = s1_item.last ? '0 : (mask_q | hit_groups);
        end
        default: begin
          mask_d = mask_q;
        end
      endcase
    end
  end

  // Result register: load on a finished vector, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && gives_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && gives_result) begin
      ok_q <= ok_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vector_ok_o = ok_q;

endmodule

// ===== rtl/vrpf_in_stage.sv =====
// Input register of the filter: captures one word per handshake.
// Depends on vrpf_pkg for the item_t word type.
module vrpf_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vrpf_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output vrpf_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  vrpf_pkg::item_t item_q;

  // Take a new word when empty or when the held word moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/vrpf_rule_bank.sv =====
// Rule table with one range comparator per slot, all evaluated in parallel.
// Depends on vrpf_pkg for item_t and bank_ctrl_t.
module vrpf_rule_bank #(
  parameter int unsigned RULES      = 16,
  parameter int unsigned GROUPS     = 16,
  parameter int unsigned DIM_BITS   = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vrpf_pkg::bank_ctrl_t ctrl_i,
  input  vrpf_pkg::item_t      item_i,
  output logic [GROUPS-1:0]    hit_groups_o,
  output logic [GROUPS-1:0]    need_groups_o
);

  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [RULES-1:0]                  used_q;
  logic [GW-1:0]                     grp_q  [RULES];
  logic [DIM_BITS-1:0]               dim_q  [RULES];
  logic signed [VALUE_BITS-1:0]      lo_q   [RULES];
  logic signed [VALUE_BITS-1:0]      hi_q   [RULES];

  logic [7:0]                        slot_ext;
  logic [7:0]                        grp_ext;
  logic [15:0]                       rdim_ext;
  logic [15:0]                       edim_ext;
  logic [63:0]                       lo_ext;
  logic [63:0]                       hi_ext;
  logic [63:0]                       val_ext;
  logic signed [VALUE_BITS-1:0]      elem_val;
  logic [DIM_BITS-1:0]               elem_dim;
  logic                              load_ok;
  logic [RULES-1:0]                  rule_hit;

  // Trim fields to the configured widths; values above 32 bits stay positive
  assign slot_ext = 8'(item_i.slot);
  assign grp_ext  = 8'(item_i.group);
  assign rdim_ext = 16'(item_i.rule_dim);
  assign edim_ext = 16'(item_i.elem_index);
  assign lo_ext   = 64'(unsigned'(item_i.range_low));
  assign hi_ext   = 64'(unsigned'(item_i.range_high));
  assign val_ext  = 64'(unsigned'(item_i.elem_value));
  assign elem_val = signed'(val_ext[VALUE_BITS-1:0]);
  assign elem_dim = edim_ext[DIM_BITS-1:0];

  // Drop loads aimed at a slot or group that does not exist
  assign load_ok = ctrl_i.load && (32'(item_i.slot) < RULES) && (32'(item_i.group) < GROUPS);

  // Valid bits: clear wipes all, a load marks its slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.clear) begin
      used_q <= '0;
    end else begin
      for (int r = 0; r < RULES; r++) begin
        if (load_ok && slot_ext == 8'(r)) begin
          used_q[r] <= 1'b1;
        end
      end
    end
  end

  // Rule contents, written only by a load to the entry's own slot
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < RULES; r++) begin
      if (load_ok && slot_ext == 8'(r)) begin
        grp_q[r] <= grp_ext[GW-1:0];
        dim_q[r] <= rdim_ext[DIM_BITS-1:0];
        lo_q[r]  <= signed'(lo_ext[VALUE_BITS-1:0]);
        hi_q[r]  <= signed'(hi_ext[VALUE_BITS-1:0]);
      end
    end
  end

  // Compare the element against every rule at once
  always_comb begin
    for (int r = 0; r < RULES; r++) begin
      rule_hit[r] = used_q[r] && (dim_q[r] == elem_dim) &&
                    (lo_q[r] <= elem_val) && (elem_val <= hi_q[r]);
    end
  end

  // Fold rules onto their groups
  always_comb begin
    hit_groups_o  = '0;
    need_groups_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      for (int r = 0; r < RULES; r++) begin
        if (grp_q[r] == GW'(g)) begin
          need_groups_o[g] = need_groups_o[g] | used_q[r];
          hit_groups_o[g]  = hit_groups_o[g] | rule_hit[r];
        end
      end
    end
  end

endmodule
